// ===== rtl/ihc_pkg.sv =====
// shared types and constants for the ipv4 header check
package ihc_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned VERDICT_W  = 3;
    localparam int unsigned COUNT_W    = 4;

    localparam logic [COUNT_W-1:0] HDR_WORDS   = 4'd10;
    localparam logic [COUNT_W-1:0] IDX_VER_IHL = 4'd0;
    localparam logic [COUNT_W-1:0] IDX_TTL     = 4'd4;
    localparam logic [COUNT_W-1:0] IDX_DST_HI  = 4'd8;
    localparam logic [COUNT_W-1:0] IDX_LAST    = 4'd9;

    localparam logic [ADDR_W-1:0] BCAST_ADDR   = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] SUM_GOOD     = 16'hffff;
    localparam logic [3:0]        IPV4_VERSION = 4'd4;
    localparam logic [3:0]        MIN_IHL      = 4'd5;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT   = 3'd0,
        V_VERSION  = 3'd1,
        V_HDR_LEN  = 3'd2,
        V_TTL_ZERO = 3'd3,
        V_DEST     = 3'd4,
        V_CHECKSUM = 3'd5
    } t_verdict;

endpackage

// ===== rtl/ihc_channels.sv =====
// valid/ready channel interfaces for the ipv4 header check
interface ihc_word_if;
    logic                        valid;
    logic                        ready;
    logic [ihc_pkg::WORD_W-1:0]  header_word;
    logic                        first_word;

    modport source (output valid, output header_word, output first_word, input ready);
    modport sink   (input valid, input header_word, input first_word, output ready);
endinterface

interface ihc_verdict_if;
    logic                          valid;
    logic                          ready;
    logic [ihc_pkg::VERDICT_W-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

interface ihc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ihc_pkg::ADDR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ipv4_header_check.sv =====
// ipv4 header check: ten header words in, one verdict out
// Takes one 16-bit header word per cycle on i_in while i_in.ready is high;
// a word with first_word set restarts the header. Capture registers and a
// running one's-complement sum are updated as each word is accepted, and
// when the tenth word is accepted the verdict is formed in the same cycle
// and loaded into the output register, so it is offered on o_out from the
// following cycle. The input is ready whenever that output register is
// empty or being drained, which gives one word per cycle sustained; words
// past the tenth without a new first_word are dropped. local_address is
// written through i_cfg, which is always ready.
module ipv4_header_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ihc_word_if.sink             i_in,
    ihc_verdict_if.source        o_out,
    ihc_cfg_if.sink              i_cfg
);

    logic [ihc_pkg::ADDR_W-1:0]  r_local_addr;
    logic [ihc_pkg::COUNT_W-1:0] r_word_count, n_word_count;
    logic [ihc_pkg::WORD_W-1:0]  r_ones_sum, n_ones_sum;
    logic [3:0]                  r_version, n_version;
    logic [3:0]                  r_hdr_len, n_hdr_len;
    logic [7:0]                  r_ttl, n_ttl;
    logic [ihc_pkg::WORD_W-1:0]  r_dest_high, n_dest_high;
    logic                        r_out_valid, n_out_valid;
    ihc_pkg::t_verdict           r_verdict, n_verdict;

    logic                        w_in_xfer;
    logic                        w_out_xfer;
    logic [ihc_pkg::COUNT_W-1:0] w_idx;
    logic [ihc_pkg::WORD_W-1:0]  w_base_sum;
    logic [ihc_pkg::WORD_W:0]    w_raw_sum;
    logic [ihc_pkg::WORD_W-1:0]  w_fold_sum;
    logic [ihc_pkg::ADDR_W-1:0]  w_dest;
    logic                        w_take;

    assign i_cfg.ready  = 1'b1;
    assign w_out_xfer   = r_out_valid && o_out.ready;
    assign i_in.ready   = !r_out_valid || o_out.ready;
    assign w_in_xfer    = i_in.valid && i_in.ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.verdict = r_verdict;

    // first_word clears count and sum before the word goes in
    assign w_idx      = i_in.first_word ? '0 : r_word_count;
    assign w_base_sum = i_in.first_word ? '0 : r_ones_sum;
    assign w_take     = w_in_xfer && (w_idx < ihc_pkg::HDR_WORDS);

    // end-around carry fold
    assign w_raw_sum  = {1'b0, w_base_sum} + {1'b0, i_in.header_word};
    assign w_fold_sum = w_raw_sum[ihc_pkg::WORD_W-1:0]
                      + {{(ihc_pkg::WORD_W-1){1'b0}}, w_raw_sum[ihc_pkg::WORD_W]};
    assign w_dest     = {r_dest_high, i_in.header_word};

    always_comb begin
        n_word_count = r_word_count;
        n_ones_sum   = r_ones_sum;
        n_version    = r_version;
        n_hdr_len    = r_hdr_len;
        n_ttl        = r_ttl;
        n_dest_high  = r_dest_high;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_verdict    = r_verdict;

        if (w_in_xfer && i_in.first_word) begin
            n_word_count = '0;
            n_ones_sum   = '0;
        end

        if (w_take) begin
            n_word_count = w_idx + 4'd1;
            n_ones_sum   = w_fold_sum;
            if (w_idx == ihc_pkg::IDX_VER_IHL) begin
                n_version = i_in.header_word[15:12];
                n_hdr_len = i_in.header_word[11:8];
            end else if (w_idx == ihc_pkg::IDX_TTL) begin
                n_ttl = i_in.header_word[15:8];
            end else if (w_idx == ihc_pkg::IDX_DST_HI) begin
                n_dest_high = i_in.header_word;
            end

            if (w_idx == ihc_pkg::IDX_LAST) begin
                n_out_valid = 1'b1;
                if (r_version != ihc_pkg::IPV4_VERSION) begin
                    n_verdict = ihc_pkg::V_VERSION;
                end else if (r_hdr_len < ihc_pkg::MIN_IHL) begin
                    n_verdict = ihc_pkg::V_HDR_LEN;
                end else if (r_ttl == 8'd0) begin
                    n_verdict = ihc_pkg::V_TTL_ZERO;
                end else if (w_dest != r_local_addr && w_dest != ihc_pkg::BCAST_ADDR) begin
                    n_verdict = ihc_pkg::V_DEST;
                end else if (w_fold_sum != ihc_pkg::SUM_GOOD) begin
                    n_verdict = ihc_pkg::V_CHECKSUM;
                end else begin
                    n_verdict = ihc_pkg::V_ACCEPT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
            r_word_count <= '0;
            r_ones_sum   <= '0;
            r_version    <= '0;
            r_hdr_len    <= '0;
            r_ttl        <= '0;
            r_dest_high  <= '0;
            r_out_valid  <= 1'b0;
            r_verdict    <= ihc_pkg::V_ACCEPT;
        end else begin
            if (i_cfg.valid) begin
                r_local_addr <= i_cfg.data;
            end
            r_word_count <= n_word_count;
            r_ones_sum   <= n_ones_sum;
            r_version    <= n_version;
            r_hdr_len    <= n_hdr_len;
            r_ttl        <= n_ttl;
            r_dest_high  <= n_dest_high;
            r_out_valid  <= n_out_valid;
            r_verdict    <= n_verdict;
        end
    end

    // count saturates at the header length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_count <= ihc_pkg::HDR_WORDS)
        else $error("word count past header length");

    // words past the tenth leave the count where it is
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && !i_in.first_word && r_word_count == ihc_pkg::HDR_WORDS)
        |=> r_word_count == ihc_pkg::HDR_WORDS)
        else $error("extra words changed the count");

    // a fresh verdict only follows acceptance of the last header word
    a_verdict_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || w_out_xfer) && !(w_take && w_idx == ihc_pkg::IDX_LAST)
        |=> !r_out_valid)
        else $error("verdict without last header word");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_verdict <= ihc_pkg::V_CHECKSUM)
        else $error("verdict code out of range");

endmodule
